>>> rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared request and response types, control enums and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Width of a cell position on the ports.
  localparam int POS_W = 11;

  // Character and attribute codes.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h5C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] ATTR_BLANK = 8'h07;
  localparam logic [15:0] CELL_BLANK = {ATTR_BLANK, CH_SPACE};

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_LINE = 2'd1,
    KIND_READ = 2'd2,
    KIND_SETC = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         ch;
    logic [7:0]         color;
    logic               last;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]   cursor_now;
    logic [7:0]         cell_char;
    logic [7:0]         cell_attr;
  } rsp_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_LINE,
    ST_SETTLE,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_READ,
    ST_DIVIDE
  } state_t;

  // Work still pending for the current request.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUT,
    ACT_LINE,
    ACT_READ,
    ACT_SETC
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic put;
    logic put_bs;
    logic line;
    logic scroll_step;
    logic scroll_end;
    logic clear_step;
    logic read;
    logic div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_ovf;
    logic sc_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer controller
// Decodes each request, tracks a held backslash and sequences the datapath
// through writes, line moves, scrolls, reads and cursor loads.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tcw_pkg::req_t req,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);
  import tcw_pkg::*;

  state_t state, state_next;
  act_t   act, act_next;
  logic   pend_bs, pend_bs_next;
  logic   held, held_next;
  logic   scroll_to_put, scroll_to_put_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      act           <= ACT_NONE;
      pend_bs       <= 1'b0;
      held          <= 1'b0;
      scroll_to_put <= 1'b0;
    end else begin
      state         <= state_next;
      act           <= act_next;
      pend_bs       <= pend_bs_next;
      held          <= held_next;
      scroll_to_put <= scroll_to_put_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next         = state;
    act_next           = act;
    pend_bs_next       = pend_bs;
    held_next          = held;
    scroll_to_put_next = scroll_to_put;
    cmd                = '0;
    done               = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.sc_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          state_next   = ST_DISPATCH;
          pend_bs_next = 1'b0;
          unique case (req.kind)
            KIND_PUT: begin
              if (held && req.ch == CH_N) begin
                // Backslash then n: a line move, nothing written.
                act_next  = ACT_LINE;
                held_next = 1'b0;
              end else begin
                // A held backslash that does not open the pair is written first.
                pend_bs_next = held;
                if (req.ch == CH_BS && !req.last) begin
                  held_next = 1'b1;
                  act_next  = ACT_NONE;
                end else if (req.ch == CH_LF) begin
                  held_next = 1'b0;
                  act_next  = ACT_LINE;
                end else begin
                  held_next = 1'b0;
                  act_next  = ACT_PUT;
                end
              end
            end
            KIND_LINE: act_next = ACT_LINE;
            KIND_READ: act_next = ACT_READ;
            KIND_SETC: act_next = ACT_SETC;
            default:   act_next = ACT_NONE;
          endcase
        end
      end
      ST_DISPATCH: begin
        if (pend_bs || act == ACT_PUT) begin
          state_next = ST_PUT;
        end else begin
          unique case (act)
            ACT_LINE: state_next = ST_LINE;
            ACT_READ: state_next = ST_READ;
            ACT_SETC: state_next = ST_DIVIDE;
            default: begin
              done       = 1'b1;
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_PUT: begin
        if (sts.cur_ovf) begin
          scroll_to_put_next = 1'b1;
          state_next         = ST_SCROLL;
        end else begin
          cmd.put    = 1'b1;
          cmd.put_bs = pend_bs;
          if (pend_bs) begin
            pend_bs_next = 1'b0;
          end else begin
            act_next = ACT_NONE;
          end
          state_next = ST_DISPATCH;
        end
      end
      ST_LINE: begin
        cmd.line   = 1'b1;
        state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (sts.cur_ovf) begin
          scroll_to_put_next = 1'b0;
          state_next         = ST_SCROLL;
        end else begin
          act_next   = ACT_NONE;
          state_next = ST_DISPATCH;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.sc_last) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: begin
        cmd.scroll_end = 1'b1;
        state_next     = scroll_to_put ? ST_PUT : ST_SETTLE;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        act_next   = ACT_NONE;
        state_next = ST_DISPATCH;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          act_next   = ACT_NONE;
          state_next = ST_DISPATCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result always returns the block to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block not idle after a result");

  // An accepted request occupies the block.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block idle right after accepting a request");

  // Only character requests may change the held backslash.
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.kind != KIND_PUT) |=> held == $past(held))
    else $error("held backslash changed by a non-character request");

endmodule
`default_nettype wire

>>> rtl/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory with a registered write stage, cursor and column registers,
// the scroll and clear address counter and a reciprocal-multiply column unit.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_pkg::req_t req,
  input  wire tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t      sts,
  output tcw_pkg::rsp_t      rsp
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CMAX  = ((CELLS > 2047) ? CELLS : 2047) + COLS;
  localparam int CW    = $clog2(CMAX + 1);
  localparam int CLW   = $clog2(COLS);
  localparam logic [CLW:0] COLS_X = (CLW + 1)'(COLS);

  // Reciprocal of COLS, exact for every position that fits POS_W bits.
  localparam int DS = POS_W + $clog2(COLS);
  localparam int DM = ((1 << DS) + COLS - 1) / COLS;
  localparam int MW = POS_W + 2;
  localparam int PW = POS_W + MW;
  localparam logic [MW-1:0]    DM_X   = MW'(DM);
  localparam logic [POS_W-1:0] COLS_P = POS_W'(COLS);

  // Screen memory.
  logic [15:0] mem [CELLS];

  // Latched request fields.
  logic [7:0]       ch;
  logic [7:0]       color;
  logic [POS_W-1:0] pos;

  // Cursor as a linear index plus its column.
  logic [CW-1:0]  cursor;
  logic [CLW-1:0] col;

  // Column unit.
  logic [PW-1:0]    prod;
  logic [POS_W-1:0] quot;
  logic             div_phase;

  // Scroll and clear counter.
  logic [AW-1:0] sc;
  logic          sc_copy;

  // Write stage and read port.
  logic          wv;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          wcopy;
  logic          ren;
  logic [AW-1:0] raddr;
  logic [15:0]   rd_data;
  logic          rd_ok;

  // Status toward the controller.
  assign sts.cur_ovf  = (cursor >= CW'(CELLS));
  assign sts.sc_last  = (sc == AW'(CELLS - 1));
  assign sts.div_last = div_phase;

  // Row number of the latched position by reciprocal multiplication.
  assign prod = PW'(pos) * PW'(DM_X);

  // Cells above the last row are copied from one row further down.
  assign sc_copy = cmd.scroll_step && (sc < AW'(CELLS - COLS));

  // Read port address.
  assign ren   = cmd.read || sc_copy;
  assign raddr = cmd.read ? AW'(pos) : sc + AW'(COLS);

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch    <= req.ch;
      color <= req.color;
      pos   <= req.position;
    end
  end

  // Cursor, column and column unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      col    <= '0;
    end else if (cmd.load && req.kind == KIND_SETC) begin
      cursor <= CW'(req.position);
    end else if (cmd.put) begin
      cursor <= cursor + CW'(1);
      col    <= (col == CLW'(COLS - 1)) ? '0 : col + CLW'(1);
    end else if (cmd.line) begin
      cursor <= cursor - CW'(col) + CW'(COLS);
      col    <= '0;
    end else if (cmd.scroll_end) begin
      cursor <= cursor - CW'(COLS);
    end else if (cmd.div_step && sts.div_last) begin
      col <= CLW'(pos - quot * COLS_P);
    end
  end

  // The first column step registers the row, the second the column.
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      div_phase <= 1'b0;
    end else if (cmd.div_step) begin
      div_phase <= !div_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      quot <= POS_W'(prod >> DS);
    end
  end

  // Scroll and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0;
    end else if (cmd.scroll_step || cmd.clear_step) begin
      sc <= sts.sc_last ? '0 : sc + AW'(1);
    end
  end

  // Write stage: every memory write is registered here before it reaches the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= cmd.put || cmd.scroll_step || cmd.clear_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      waddr <= AW'(cursor);
      wdata <= {color, (cmd.put_bs ? CH_BS : ch)};
      wcopy <= 1'b0;
    end else begin
      waddr <= sc;
      wdata <= CELL_BLANK;
      wcopy <= sc_copy;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wv) begin
      mem[waddr] <= wcopy ? rd_data : wdata;
    end
    if (ren) begin
      rd_data <= mem[raddr];
    end
  end

  // Read result is shown only for an in-range read of this request.
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      rd_ok <= 1'b0;
    end else if (cmd.read) begin
      rd_ok <= (CW'(pos) < CW'(CELLS));
    end
  end

  assign rsp.cursor_now = cursor[POS_W-1:0];
  assign rsp.cell_char  = rd_ok ? rd_data[7:0]  : 8'h00;
  assign rsp.cell_attr  = rd_ok ? rd_data[15:8] : 8'h00;

  // A character is never written at or past the end of the screen.
  a_put_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !sts.cur_ovf)
    else $error("cell write with cursor past the screen");

  // The sweep counter wraps to zero after its last cell.
  a_sweep_wrap: assert property (@(posedge clk) disable iff (rst)
    ((cmd.scroll_step || cmd.clear_step) && sts.sc_last) |=> sc == '0)
    else $error("sweep counter did not wrap");

  // The column stays inside a row.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < COLS_X)
    else $error("cursor column out of range");

endmodule
`default_nettype wire

>>> rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// COLS by ROWS character screen with a cursor, line moves and scrolling.
// ----------------------------------------------------------------------------
// Usage: a request on req is accepted at a rising edge with start high and
// busy low. Each request yields one response on rsp, valid for the single
// cycle in which done is high; the receiver cannot stall it.
// Steps from the accepting edge to done, without scrolling:
//   character write: put, then done (a held backslash is written first),
//   a backslash that is only held: straight to done (after writing an earlier
//   held one), read: cell read, then done, new line: line move and overflow
//   check, set cursor: the row step and then the column step in the column unit.
// The block takes no new request while busy, so requests do not overlap.
// Each scroll walks every cell through the single write port; a cursor set
// past the end scrolls once per excess row at the next write or new line.
// After reset the screen memory is cleared to space with attribute 0x07 in a
// pass over all COLS*ROWS cells, during which busy stays high. The cursor and the
// held backslash reset to zero.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tcw_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output tcw_pkg::rsp_t      rsp
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Screen memory and cursor.
  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
`default_nettype wire
